// ===== sv/tppwm_pkg.sv =====
package tppwm_pkg;

    // Default structure sizes
    localparam int COUNT_WIDTH_DEF = 16;
    localparam int DEAD_WIDTH_DEF  = 7;
    localparam int PHASE_COUNT_DEF = 3;

    // Fixed field widths of the stream and register interfaces
    localparam int DUTY_W      = 17;
    localparam int DUTY_INPUTS = 3;
    localparam int TOP_CFG_W   = 16;
    localparam int DEAD_CFG_W  = 7;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int FUNC_W      = 2;
    localparam int COUNT_OUT_W = 16;
    localparam int S_TDATA_W   = 56;
    localparam int M_TDATA_W   = 32;

    // 0.4 in Q16, rounding offset of the duty conversion
    localparam logic [DUTY_W-1:0] ROUND_Q16 = 17'd26214;
    localparam int TOP_RESET = 4499;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_LOAD  = 2'd1,
        FUNC_ZERO  = 2'd2,
        FUNC_ESTOP = 2'd3
    } func_t;

    localparam logic [CFG_INDEX_W-1:0] REG_PERIOD_TOP = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DEAD_TICKS = 2'd1;

    typedef struct packed {
        logic high;
        logic low;
    } gate_drive_t;

endpackage

// ===== sv/tppwm_duty_conv.sv =====
module tppwm_duty_conv #(
    parameter int COUNT_WIDTH = tppwm_pkg::COUNT_WIDTH_DEF
) (
    input  logic [tppwm_pkg::DUTY_W-1:0] duty,
    input  logic [COUNT_WIDTH-1:0]       top,
    output logic [COUNT_WIDTH-1:0]       cmp
);
    import tppwm_pkg::*;

    localparam int PROD_W = DUTY_W + COUNT_WIDTH;

    logic [PROD_W-1:0]      prod;
    logic [PROD_W:0]        sum;
    logic [COUNT_WIDTH+1:0] scaled;

    assign prod   = PROD_W'(duty) * PROD_W'(top);
    assign sum    = {1'b0, prod} + (PROD_W + 1)'(ROUND_Q16);
    assign scaled = sum[PROD_W:16];

    // saturate at the turning point
    always_comb begin
        if (scaled > {2'b00, top}) begin
            cmp = top;
        end else begin
            cmp = scaled[COUNT_WIDTH-1:0];
        end
    end

endmodule

// ===== sv/tppwm_phase.sv =====
module tppwm_phase #(
    parameter int COUNT_WIDTH = tppwm_pkg::COUNT_WIDTH_DEF,
    parameter int DEAD_WIDTH  = tppwm_pkg::DEAD_WIDTH_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    step,
    input  logic [COUNT_WIDTH-1:0]  count_next,
    input  logic [COUNT_WIDTH-1:0]  cmp_next,
    input  logic [DEAD_WIDTH-1:0]   dead_ticks,
    output tppwm_pkg::gate_drive_t  drive_next
);
    import tppwm_pkg::*;

    logic                  ref_reg, ref_next;
    logic [DEAD_WIDTH-1:0] dead_reg, dead_next;
    logic                  level;

    always_comb begin
        level     = count_next < cmp_next;
        ref_next  = ref_reg;
        dead_next = dead_reg;
        if (level != ref_reg) begin
            ref_next  = level;
            dead_next = dead_ticks;
        end else if (dead_reg != '0) begin
            dead_next = dead_reg - DEAD_WIDTH'(1);
        end
        // hold both sides off while the dead time runs
        drive_next.high = (dead_next == '0) && ref_next;
        drive_next.low  = (dead_next == '0) && !ref_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_reg  <= 1'b0;
            dead_reg <= '0;
        end else if (step) begin
            ref_reg  <= ref_next;
            dead_reg <= dead_next;
        end
    end

endmodule

// ===== sv/three_phase_pwm_dead_time.sv =====
// Center-aligned three-phase PWM with complementary outputs and dead time.
// Each request on the s_ channel is one timer tick: s_tuser carries the
// function (tick, load duties, zero duties, emergency stop), s_tdata the three
// Q16 duties and the break pin level. Every request yields exactly one result
// on the m_ channel with the six gate drives, sync level, counter, direction
// and trip flag as they stand after that tick.
// Duties are converted to compares (one 17 x COUNT_WIDTH multiply per phase)
// ahead of the input stage; the counter, compares and dead-time counters update
// when the request moves from the input stage into the output register. A
// taken request is held in the input stage until the output register is free
// to load its result, and one request per cycle is accepted when the receiver
// keeps m_tready high.
// While the receiver stalls, the output register holds its result and the
// input stage can still take one more request; s_tready then drops.
// Registers are written on cfg_we through cfg_index/cfg_wdata (unknown indexes
// are ignored); writing only while the stream is idle is left to the user.
// Reset (aresetn low, synchronous) clears the counter, compares, dead time,
// trip latch and halt, and restores period_top 4499 and dead_ticks 0.
module three_phase_pwm_dead_time #(
    parameter int COUNT_WIDTH = tppwm_pkg::COUNT_WIDTH_DEF,
    parameter int DEAD_WIDTH  = tppwm_pkg::DEAD_WIDTH_DEF,
    parameter int PHASE_COUNT = tppwm_pkg::PHASE_COUNT_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [tppwm_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [tppwm_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // duty_a[16:0], duty_b[33:17], duty_c[50:34], break_in[51], zero fill
    input  logic [tppwm_pkg::S_TDATA_W-1:0]     s_tdata,
    // func[1:0]
    input  logic [tppwm_pkg::FUNC_W-1:0]        s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // high_a[0], low_a[1], high_b[2], low_b[3], high_c[4], low_c[5],
    // sync_out[6], count_now[22:7], counting_down[23], tripped[24], zero fill
    output logic [tppwm_pkg::M_TDATA_W-1:0]     m_tdata
);
    import tppwm_pkg::*;

    // phases beyond the three duty inputs have no visible effect
    localparam int PH_N = (PHASE_COUNT < DUTY_INPUTS) ? PHASE_COUNT : DUTY_INPUTS;

    // configuration
    logic [COUNT_WIDTH-1:0]            top_reg;
    logic [DEAD_WIDTH-1:0]             dead_ticks_reg;
    logic [COUNT_WIDTH+TOP_CFG_W-1:0]  top_wide;
    logic [DEAD_WIDTH+DEAD_CFG_W-1:0]  dead_wide;

    assign top_wide  = {{COUNT_WIDTH{1'b0}}, cfg_wdata[TOP_CFG_W-1:0]};
    assign dead_wide = {{DEAD_WIDTH{1'b0}}, cfg_wdata[DEAD_CFG_W-1:0]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_reg        <= COUNT_WIDTH'(TOP_RESET);
            dead_ticks_reg <= '0;
        end else if (cfg_we) begin
            if (cfg_index == REG_PERIOD_TOP) begin
                top_reg <= top_wide[COUNT_WIDTH-1:0];
            end else if (cfg_index == REG_DEAD_TICKS) begin
                dead_ticks_reg <= dead_wide[DEAD_WIDTH-1:0];
            end
        end
    end

    // handshake
    logic s1_valid_reg;
    logic m_tvalid_reg;
    logic out_free, s1_adv, s_acc;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s1_adv   = s1_valid_reg && out_free;
    assign s_tready = !s1_valid_reg || out_free;
    assign s_acc    = s_tvalid && s_tready;

    // input stage: duty conversion
    logic [COUNT_WIDTH-1:0] cmp_in [PH_N];
    logic [COUNT_WIDTH-1:0] s1_cmp_reg [PH_N];
    func_t                  s1_func_reg;
    logic                   s1_break_reg;

    for (genvar i = 0; i < PH_N; i++) begin : g_conv
        tppwm_duty_conv #(
            .COUNT_WIDTH (COUNT_WIDTH)
        ) u_conv (
            .duty (s_tdata[DUTY_W*i +: DUTY_W]),
            .top  (top_reg),
            .cmp  (cmp_in[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_acc) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            s1_cmp_reg   <= cmp_in;
            s1_func_reg  <= func_t'(s_tuser);
            s1_break_reg <= s_tdata[DUTY_W*DUTY_INPUTS];
        end
    end

    // timer state
    logic [COUNT_WIDTH-1:0] cnt_reg, cnt_next, cnt_inc;
    logic                   down_reg, down_next;
    logic                   sync_reg, sync_next;
    logic                   trip_reg, trip_next;
    logic                   halt_reg, halt_next;
    logic                   load;
    logic [COUNT_WIDTH-1:0] shadow_reg [PH_N];
    logic [COUNT_WIDTH-1:0] shadow_next [PH_N];
    logic [COUNT_WIDTH-1:0] active_reg [PH_N];
    logic [COUNT_WIDTH-1:0] active_next [PH_N];

    assign cnt_inc = cnt_reg + COUNT_WIDTH'(1);

    always_comb begin
        for (int i = 0; i < PH_N; i++) begin
            unique case (s1_func_reg)
                FUNC_LOAD: shadow_next[i] = s1_cmp_reg[i];
                FUNC_ZERO: shadow_next[i] = '0;
                default:   shadow_next[i] = shadow_reg[i];
            endcase
        end
        trip_next = trip_reg || (s1_func_reg == FUNC_ESTOP) || s1_break_reg;
        halt_next = halt_reg || (s1_func_reg == FUNC_ESTOP);

        cnt_next  = cnt_reg;
        down_next = down_reg;
        sync_next = sync_reg;
        load      = 1'b0;
        if (!halt_next) begin
            if (!down_reg) begin
                if ((cnt_reg >= top_reg) || (cnt_inc >= top_reg)) begin
                    cnt_next  = top_reg;
                    down_next = 1'b1;
                    load      = 1'b1;
                end else begin
                    cnt_next = cnt_inc;
                end
            end else begin
                if (cnt_reg <= COUNT_WIDTH'(1)) begin
                    cnt_next  = '0;
                    down_next = 1'b0;
                    sync_next = !sync_reg;
                    load      = 1'b1;
                end else begin
                    cnt_next = cnt_reg - COUNT_WIDTH'(1);
                end
            end
        end

        for (int i = 0; i < PH_N; i++) begin
            active_next[i] = load ? shadow_next[i] : active_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            down_reg <= 1'b0;
            sync_reg <= 1'b0;
            trip_reg <= 1'b0;
            halt_reg <= 1'b0;
            for (int i = 0; i < PH_N; i++) begin
                shadow_reg[i] <= '0;
                active_reg[i] <= '0;
            end
        end else if (s1_adv) begin
            cnt_reg    <= cnt_next;
            down_reg   <= down_next;
            sync_reg   <= sync_next;
            trip_reg   <= trip_next;
            halt_reg   <= halt_next;
            shadow_reg <= shadow_next;
            active_reg <= active_next;
        end
    end

    // per-phase reference and dead time
    gate_drive_t drive [PH_N];
    gate_drive_t gate [DUTY_INPUTS];

    for (genvar i = 0; i < PH_N; i++) begin : g_phase
        tppwm_phase #(
            .COUNT_WIDTH (COUNT_WIDTH),
            .DEAD_WIDTH  (DEAD_WIDTH)
        ) u_phase (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .step       (s1_adv),
            .count_next (cnt_next),
            .cmp_next   (active_next[i]),
            .dead_ticks (dead_ticks_reg),
            .drive_next (drive[i])
        );
    end

    for (genvar i = 0; i < DUTY_INPUTS; i++) begin : g_gate
        if (i < PH_N) begin : g_live
            assign gate[i].high = drive[i].high && !trip_next;
            assign gate[i].low  = drive[i].low && !trip_next;
        end else begin : g_off
            assign gate[i] = '0;
        end
    end

    // result register
    logic [COUNT_WIDTH+COUNT_OUT_W-1:0] cnt_wide;
    logic [M_TDATA_W-1:0]               m_tdata_reg, m_tdata_next;

    assign cnt_wide = {{COUNT_OUT_W{1'b0}}, cnt_next};
    assign m_tdata_next = {
        (M_TDATA_W - 25)'(0),
        trip_next,
        down_next,
        cnt_wide[COUNT_OUT_W-1:0],
        sync_next,
        gate[2].low, gate[2].high,
        gate[1].low, gate[1].high,
        gate[0].low, gate[0].high
    };

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s1_adv) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // checks
    a_trip_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        trip_reg |=> trip_reg)
        else $error("trip latch released without reset");

    a_halt_freezes: assert property (@(posedge aclk) disable iff (!aresetn)
        halt_reg |=> $stable(cnt_reg) && $stable(down_reg) && $stable(sync_reg))
        else $error("counter moved while halted");

    a_tripped_gates_off: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tdata_reg[24]) |-> (m_tdata_reg[5:0] == 6'd0))
        else $error("gate drive active while tripped");

    a_no_shoot_through: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> !(m_tdata_reg[0] && m_tdata_reg[1])
                      && !(m_tdata_reg[2] && m_tdata_reg[3])
                      && !(m_tdata_reg[4] && m_tdata_reg[5]))
        else $error("high and low side driven together");

endmodule
